// ===== hw/rtl/quaternion_attitude_pid_macros.svh =====
// ----------------------------------------------------------------------------
// quaternion attitude pid assertion macros
// shared concurrent check templates for the attitude controller checkers
// ----------------------------------------------------------------------------
`ifndef QUATERNION_ATTITUDE_PID_MACROS_SVH
`define QUATERNION_ATTITUDE_PID_MACROS_SVH

// same-cycle implication, held off while reset is low
`define QAP_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
	else $error("quaternion attitude pid check failed");

// next-cycle implication, held off while reset is low
`define QAP_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
	else $error("quaternion attitude pid check failed");

`endif

// ===== hw/rtl/qap_pkg.sv =====
// ----------------------------------------------------------------------------
// qap_pkg
// types, constants and small tables of the quaternion attitude controller
// ----------------------------------------------------------------------------
package qap_pkg;

	localparam int IN_ITEM_W  = 128;
	localparam int OUT_ITEM_W = 72;
	localparam int GAIN_W     = 48;
	localparam int CFG_ADDR_W = 2;
	localparam int FLD_W      = 16;
	localparam int DRV_W      = 24;

	localparam int TAB_LEN = 24;
	localparam int IDX_W   = $clog2(TAB_LEN);
	localparam int Z_W     = 26;
	localparam int CX_W    = 36;
	// euler terms reach +-2^32 with full-scale 16-bit components
	localparam int IN_W    = 34;
	localparam int REM_W   = 57;
	localparam int ROOT_W  = 29;
	localparam int ANG_W   = 18;
	localparam int ERR_W   = 17;

	localparam logic signed [Z_W-1:0]  PI_Q20      = 26'sd3294199;
	localparam logic signed [Z_W-1:0]  HALF_PI_Q20 = 26'sd1647099;
	localparam logic signed [IN_W-1:0] ONE_Q28     = 34'sd268435456;
	localparam logic [REM_W-1:0]       REM_TOP     = {1'b1, {(REM_W-1){1'b0}}};

	// configuration register indexes
	localparam logic [CFG_ADDR_W-1:0] REG_GAINS_ROLL  = 2'd0;
	localparam logic [CFG_ADDR_W-1:0] REG_GAINS_PITCH = 2'd1;
	localparam logic [CFG_ADDR_W-1:0] REG_GAINS_YAW   = 2'd2;

	typedef enum logic [3:0] {
		S_IDLE, S_MUL, S_ACC, S_ROLL_GO, S_ROLL_WT, S_PCHK, S_SQ_WT, S_PITCH_GO,
		S_PITCH_WT, S_YAW_GO, S_YAW_WT, S_PREP, S_PMUL, S_PACC, S_FIN, S_OUT
	} state_t;

	// product sequence: euler terms first, then p, i, d per axis
	typedef enum logic [3:0] {
		OP_WX, OP_YZ, OP_XX, OP_YY, OP_WY, OP_ZX, OP_WZ, OP_XY, OP_YY2, OP_ZZ,
		OP_SPSP, OP_KP, OP_KI, OP_KD
	} op_t;

	// rounded atan(2^-i) in q.20 radians
	function automatic logic [Z_W-1:0] atan_tab(input logic [IDX_W-1:0] idx);
		logic [Z_W-1:0] v;
		unique case (idx)
			5'd0:    v = 26'd823550;
			5'd1:    v = 26'd486170;
			5'd2:    v = 26'd256879;
			5'd3:    v = 26'd130396;
			5'd4:    v = 26'd65451;
			5'd5:    v = 26'd32757;
			5'd6:    v = 26'd16383;
			5'd7:    v = 26'd8192;
			5'd8:    v = 26'd4096;
			5'd9:    v = 26'd2048;
			5'd10:   v = 26'd1024;
			5'd11:   v = 26'd512;
			5'd12:   v = 26'd256;
			5'd13:   v = 26'd128;
			5'd14:   v = 26'd64;
			5'd15:   v = 26'd32;
			5'd16:   v = 26'd16;
			5'd17:   v = 26'd8;
			5'd18:   v = 26'd4;
			5'd19:   v = 26'd2;
			5'd20:   v = 26'd1;
			default: v = '0;
		endcase
		return v;
	endfunction

	// q.20 angle to q.12 with round half up
	function automatic logic signed [ANG_W-1:0] q12_of(input logic signed [Z_W-1:0] z);
		logic signed [Z_W:0] t;
		t = (Z_W+1)'(z) + (Z_W+1)'(128);
		return ANG_W'(t >>> 8);
	endfunction

endpackage

// ===== hw/rtl/qap_cordic.sv =====
// ----------------------------------------------------------------------------
// qap_cordic
// iterative cordic vectoring core, one micro-rotation per cycle, gives atan2
// ----------------------------------------------------------------------------
module qap_cordic #(
	parameter int STEPS = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            start,
	input  logic signed [qap_pkg::IN_W-1:0] y_in,
	input  logic signed [qap_pkg::IN_W-1:0] x_in,
	output logic                            done,
	output logic signed [qap_pkg::Z_W-1:0]  z_out
);
	import qap_pkg::*;

	localparam logic [IDX_W-1:0] LAST = IDX_W'(STEPS - 1);

	logic signed [CX_W-1:0] x_q, y_q, dx, dy;
	logic signed [Z_W-1:0]  z_q, tab;
	logic [IDX_W-1:0]       i_q;
	logic                   run_q, done_q, zero_q;

	assign dx  = y_q >>> i_q;
	assign dy  = x_q >>> i_q;
	assign tab = $signed(atan_tab(i_q));

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
			i_q    <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
				i_q   <= '0;
			end else if (run_q) begin
				i_q <= i_q + 1'b1;
				if (i_q == LAST) begin
					run_q  <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			zero_q <= (x_in == 0) && (y_in == 0);
			// left half plane: rotate by pi first
			if (x_in < 0) begin
				x_q <= -CX_W'(x_in);
				y_q <= -CX_W'(y_in);
				z_q <= (y_in >= 0) ? PI_Q20 : -PI_Q20;
			end else begin
				x_q <= CX_W'(x_in);
				y_q <= CX_W'(y_in);
				z_q <= '0;
			end
		end else if (run_q) begin
			if (y_q > 0) begin
				x_q <= x_q + dx;
				y_q <= y_q - dy;
				z_q <= z_q + tab;
			end else begin
				x_q <= x_q - dx;
				y_q <= y_q + dy;
				z_q <= z_q - tab;
			end
		end
	end

	assign done  = done_q;
	assign z_out = zero_q ? '0 : z_q;

endmodule

// ===== hw/rtl/qap_isqrt.sv =====
// ----------------------------------------------------------------------------
// qap_isqrt
// bit-pair integer square root, one result bit per cycle
// ----------------------------------------------------------------------------
module qap_isqrt (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              start,
	input  logic [qap_pkg::REM_W-1:0]         n_in,
	output logic                              done,
	output logic [qap_pkg::ROOT_W-1:0]        root
);
	import qap_pkg::*;

	logic [REM_W-1:0] n_q, r_q, b_q;
	logic [REM_W:0]   rb;
	logic             run_q, done_q;

	assign rb = (REM_W+1)'(r_q) + (REM_W+1)'(b_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			run_q  <= 1'b0;
			done_q <= 1'b0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				run_q <= 1'b1;
			end else if (run_q && b_q == REM_W'(1)) begin
				run_q  <= 1'b0;
				done_q <= 1'b1;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			n_q <= n_in;
			r_q <= '0;
			b_q <= REM_TOP;
		end else if (run_q) begin
			if ({1'b0, n_q} >= rb) begin
				n_q <= n_q - REM_W'(rb);
				r_q <= (r_q >> 1) + b_q;
			end else begin
				r_q <= r_q >> 1;
			end
			b_q <= b_q >> 2;
		end
	end

	assign done = done_q;
	assign root = r_q[ROOT_W-1:0];

endmodule

// ===== hw/rtl/quaternion_attitude_pid.sv =====
// ----------------------------------------------------------------------------
// quaternion_attitude_pid
// three-axis pid attitude controller fed by an attitude quaternion
// ----------------------------------------------------------------------------
// usage
//   s_* channel: one item carries quaternion w/x/y/z (q1.14), roll, pitch and
//   yaw targets (q3.12 rad) and a throttle. throttle <= 0 items are taken
//   without leaving idle, give no result and leave the loop state alone.
//   m_* channel: one item per enabled input, the three saturated drives.
//   cfg_*: gain registers, written by the user only while the block is idle;
//   the block itself does not enforce this.
// sequence
//   an enabled item makes three passes through the shared cordic core (two
//   when pitch saturates, which also skips the square root) and 20 products
//   on the shared multiplier. s_tready is high only when idle.
// reset
//   arst_n clears gains, integrals, previous errors and the output valid.
// stall
//   a finished result sits in the output register; the next item is already
//   taken meanwhile, and a new result waits in the sequencer until the
//   output register frees up.
// ----------------------------------------------------------------------------
module quaternion_attitude_pid #(
	parameter int CORDIC_STEPS = 16,
	parameter int SUM_WIDTH    = 32
) (
	input  logic                                clk,
	input  logic                                arst_n,
	input  logic                                s_tvalid,
	output logic                                s_tready,
	// quat_w, quat_x, quat_y, quat_z, target_roll, target_pitch, target_yaw, throttle
	input  logic [qap_pkg::IN_ITEM_W-1:0]       s_tdata,
	output logic                                m_tvalid,
	input  logic                                m_tready,
	// drive_roll, drive_pitch, drive_yaw
	output logic [qap_pkg::OUT_ITEM_W-1:0]      m_tdata,
	input  logic                                cfg_we,
	input  logic [qap_pkg::CFG_ADDR_W-1:0]      cfg_addr,
	input  logic [qap_pkg::GAIN_W-1:0]          cfg_wdata
);
	import qap_pkg::*;

	localparam int MA    = 30;
	localparam int MB    = (SUM_WIDTH > MA) ? SUM_WIDTH : MA;
	localparam int PW    = MA + MB;
	localparam int ACC_W = PW + 2;
	localparam logic signed [ACC_W-1:0] DRV_HI = ACC_W'(8388607);
	localparam logic signed [ACC_W-1:0] DRV_LO = -DRV_HI - ACC_W'(1);

	state_t state_q, state_d;
	op_t    op_q;
	logic [1:0] axis_q;

	// latched item
	logic signed [FLD_W-1:0] qw_q, qx_q, qy_q, qz_q;
	logic signed [FLD_W-1:0] tgt_q [3];
	logic [GAIN_W-1:0]       gains_q [3];
	logic [GAIN_W-1:0]       gain;

	// shared multiplier and accumulator
	logic signed [MA-1:0]    mul_a;
	logic signed [MB-1:0]    mul_b;
	logic signed [PW-1:0]    prod_q;
	logic signed [ACC_W-1:0] acc_q, prod_x, acc_add, acc_sub;

	// euler terms
	logic signed [IN_W-1:0]  sr_q, cr_q, sp_q, sy_q, cy_q;
	logic [REM_W-1:0]        rem_q;
	logic signed [ANG_W-1:0] ang_q [3];
	logic                    sp_sat;

	// pid loop state and per-axis scratch
	logic signed [SUM_WIDTH-1:0] err_sum_q [3];
	logic signed [ERR_W-1:0]     last_err_q [3];
	logic signed [SUM_WIDTH-1:0] sum_q, sum_sat;
	logic signed [SUM_WIDTH:0]   sum_w;
	logic signed [ERR_W-1:0]     e_q, e_sat;
	logic signed [ERR_W+1:0]     ediff;
	logic signed [ERR_W:0]       de_q, de_d;
	logic signed [ACC_W-1:0]     rnd;
	logic signed [DRV_W-1:0]     drv_d;
	logic signed [DRV_W-1:0]     drv_q [3];
	logic signed [DRV_W-1:0]     out_q [3];
	logic                        out_valid_q;

	// sequencer outputs
	logic                    take, enabled, crd_start, sq_start, out_load;
	logic signed [IN_W-1:0]  crd_y, crd_x;
	logic                    crd_done, sq_done;
	logic signed [Z_W-1:0]   crd_z;
	logic [ROOT_W-1:0]       root;

	assign enabled = $signed(s_tdata[127:112]) > 0;
	assign take    = s_tvalid && s_tready;
	assign gain    = gains_q[axis_q];
	assign sp_sat  = (sp_q >= ONE_Q28) || (sp_q <= -ONE_Q28);

	qap_cordic #(.STEPS(CORDIC_STEPS)) u_cordic (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (crd_start),
		.y_in   (crd_y),
		.x_in   (crd_x),
		.done   (crd_done),
		.z_out  (crd_z)
	);

	qap_isqrt u_isqrt (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (sq_start),
		.n_in   (rem_q),
		.done   (sq_done),
		.root   (root)
	);

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			S_IDLE:     if (s_tvalid && enabled) state_d = S_MUL;
			S_MUL:      state_d = S_ACC;
			S_ACC:      state_d = (op_q == OP_SPSP) ? S_ROLL_GO : S_MUL;
			S_ROLL_GO:  state_d = S_ROLL_WT;
			S_ROLL_WT:  if (crd_done) state_d = S_PCHK;
			S_PCHK:     state_d = sp_sat ? S_YAW_GO : S_SQ_WT;
			S_SQ_WT:    if (sq_done) state_d = S_PITCH_GO;
			S_PITCH_GO: state_d = S_PITCH_WT;
			S_PITCH_WT: if (crd_done) state_d = S_YAW_GO;
			S_YAW_GO:   state_d = S_YAW_WT;
			S_YAW_WT:   if (crd_done) state_d = S_PREP;
			S_PREP:     state_d = S_PMUL;
			S_PMUL:     state_d = S_PACC;
			S_PACC:     state_d = (op_q == OP_KD) ? S_FIN : S_PMUL;
			S_FIN:      state_d = (axis_q == 2'd2) ? S_OUT : S_PREP;
			S_OUT:      if (!out_valid_q || m_tready) state_d = S_IDLE;
		endcase
	end

	// sequencer outputs
	always_comb begin
		s_tready  = (state_q == S_IDLE);
		crd_start = (state_q == S_ROLL_GO) || (state_q == S_PITCH_GO) ||
			(state_q == S_YAW_GO);
		sq_start  = (state_q == S_PCHK) && !sp_sat;
		out_load  = (state_q == S_OUT) && (!out_valid_q || m_tready);
		unique case (state_q)
			S_PITCH_GO: begin
				crd_y = sp_q;
				crd_x = IN_W'(root);
			end
			S_YAW_GO: begin
				crd_y = sy_q;
				crd_x = cy_q;
			end
			default: begin
				crd_y = sr_q;
				crd_x = cr_q;
			end
		endcase
	end

	// multiplier operand select
	always_comb begin
		unique case (op_q)
			OP_WX:   begin mul_a = MA'(qw_q); mul_b = MB'(qx_q); end
			OP_YZ:   begin mul_a = MA'(qy_q); mul_b = MB'(qz_q); end
			OP_XX:   begin mul_a = MA'(qx_q); mul_b = MB'(qx_q); end
			OP_YY:   begin mul_a = MA'(qy_q); mul_b = MB'(qy_q); end
			OP_WY:   begin mul_a = MA'(qw_q); mul_b = MB'(qy_q); end
			OP_ZX:   begin mul_a = MA'(qz_q); mul_b = MB'(qx_q); end
			OP_WZ:   begin mul_a = MA'(qw_q); mul_b = MB'(qz_q); end
			OP_XY:   begin mul_a = MA'(qx_q); mul_b = MB'(qy_q); end
			OP_YY2:  begin mul_a = MA'(qy_q); mul_b = MB'(qy_q); end
			OP_ZZ:   begin mul_a = MA'(qz_q); mul_b = MB'(qz_q); end
			// only used when |sinp| < 1, so the low bits hold it whole
			OP_SPSP: begin
				mul_a = $signed(sp_q[MA-1:0]);
				mul_b = MB'($signed(sp_q[MA-1:0]));
			end
			OP_KP:   begin mul_a = MA'($signed(gain[15:0]));  mul_b = MB'(e_q);   end
			OP_KI:   begin mul_a = MA'($signed(gain[31:16])); mul_b = MB'(sum_q); end
			OP_KD:   begin mul_a = MA'($signed(gain[47:32])); mul_b = MB'(de_q);  end
			default: begin mul_a = '0; mul_b = '0; end
		endcase
	end

	assign prod_x  = ACC_W'(prod_q);
	assign acc_add = acc_q + prod_x;
	assign acc_sub = acc_q - prod_x;

	// per-axis error terms
	always_comb begin
		sum_w   = (SUM_WIDTH+1)'(err_sum_q[axis_q]) + (SUM_WIDTH+1)'(last_err_q[axis_q]);
		sum_sat = (sum_w[SUM_WIDTH] != sum_w[SUM_WIDTH-1]) ?
			{sum_w[SUM_WIDTH], {(SUM_WIDTH-1){~sum_w[SUM_WIDTH]}}} : sum_w[SUM_WIDTH-1:0];
		ediff   = (ERR_W+2)'(tgt_q[axis_q]) - (ERR_W+2)'(ang_q[axis_q]);
		e_sat   = (ediff[ERR_W+1] == ediff[ERR_W] && ediff[ERR_W] == ediff[ERR_W-1]) ?
			ediff[ERR_W-1:0] : {ediff[ERR_W+1], {(ERR_W-1){~ediff[ERR_W+1]}}};
		de_d    = (ERR_W+1)'(e_sat) - (ERR_W+1)'(last_err_q[axis_q]);
		rnd     = (acc_q + ACC_W'(128)) >>> 8;
		if (rnd > DRV_HI)
			drv_d = 24'sh7fffff;
		else if (rnd < DRV_LO)
			drv_d = 24'sh800000;
		else
			drv_d = rnd[DRV_W-1:0];
	end

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			op_q        <= OP_WX;
			axis_q      <= '0;
			out_valid_q <= 1'b0;
			for (int i = 0; i < 3; i++) begin
				gains_q[i]    <= '0;
				err_sum_q[i]  <= '0;
				last_err_q[i] <= '0;
			end
		end else begin
			state_q <= state_d;
			if (cfg_we) begin
				unique case (cfg_addr)
					REG_GAINS_ROLL:  gains_q[0] <= cfg_wdata;
					REG_GAINS_PITCH: gains_q[1] <= cfg_wdata;
					REG_GAINS_YAW:   gains_q[2] <= cfg_wdata;
					default: ;
				endcase
			end
			if (take) begin
				op_q   <= OP_WX;
				axis_q <= '0;
			end
			if (state_q == S_ACC || state_q == S_PACC)
				op_q <= (op_q == OP_KD) ? OP_KP : op_t'(op_q + 4'd1);
			if (state_q == S_FIN) begin
				err_sum_q[axis_q]  <= sum_q;
				last_err_q[axis_q] <= e_q;
				axis_q             <= axis_q + 2'd1;
			end
			if (out_load)
				out_valid_q <= 1'b1;
			else if (m_tready)
				out_valid_q <= 1'b0;
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		prod_q <= mul_a * mul_b;
		if (take) begin
			qw_q     <= s_tdata[15:0];
			qx_q     <= s_tdata[31:16];
			qy_q     <= s_tdata[47:32];
			qz_q     <= s_tdata[63:48];
			tgt_q[0] <= s_tdata[79:64];
			tgt_q[1] <= s_tdata[95:80];
			tgt_q[2] <= s_tdata[111:96];
		end
		if (state_q == S_ACC) begin
			unique case (op_q)
				OP_YZ:   sr_q  <= IN_W'(acc_add <<< 1);
				OP_YY:   cr_q  <= ONE_Q28 - IN_W'(acc_add <<< 1);
				OP_ZX:   sp_q  <= IN_W'(acc_sub <<< 1);
				OP_XY:   sy_q  <= IN_W'(acc_add <<< 1);
				OP_ZZ:   cy_q  <= ONE_Q28 - IN_W'(acc_add <<< 1);
				OP_SPSP: rem_q <= REM_TOP - prod_q[REM_W-1:0];
				default: acc_q <= prod_x;
			endcase
		end
		if (state_q == S_PACC)
			acc_q <= (op_q == OP_KP) ? prod_x : acc_add;
		if (state_q == S_ROLL_WT && crd_done)
			ang_q[0] <= q12_of(crd_z);
		if (state_q == S_PCHK && sp_sat)
			ang_q[1] <= (sp_q > 0) ? q12_of(HALF_PI_Q20) : q12_of(-HALF_PI_Q20);
		if (state_q == S_PITCH_WT && crd_done)
			ang_q[1] <= q12_of(crd_z);
		if (state_q == S_YAW_WT && crd_done)
			ang_q[2] <= q12_of(crd_z);
		if (state_q == S_PREP) begin
			sum_q <= sum_sat;
			e_q   <= e_sat;
			de_q  <= de_d;
		end
		if (state_q == S_FIN)
			drv_q[axis_q] <= drv_d;
		if (out_load) begin
			out_q[0] <= drv_q[0];
			out_q[1] <= drv_q[1];
			out_q[2] <= drv_q[2];
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = {out_q[2], out_q[1], out_q[0]};

endmodule

// ===== hw/rtl/qap_checker.sv =====
// ----------------------------------------------------------------------------
// qap_checker
// port-level checks of the attitude controller, bound to the top level
// ----------------------------------------------------------------------------
`include "quaternion_attitude_pid_macros.svh"

module qap_checker (
	input logic                                clk,
	input logic                                arst_n,
	input logic                                s_tvalid,
	input logic                                s_tready,
	input logic [qap_pkg::IN_ITEM_W-1:0]       s_tdata,
	input logic                                m_tvalid,
	input logic                                m_tready,
	input logic [qap_pkg::OUT_ITEM_W-1:0]      m_tdata
);

	// a stalled result stays offered and unchanged
	`QAP_ASSERT_NXT(a_out_hold, clk, arst_n, m_tvalid && !m_tready, m_tvalid)
	`QAP_ASSERT_NXT(a_out_stable, clk, arst_n, m_tvalid && !m_tready, $stable(m_tdata))

	// an enabled item occupies the sequencer and cannot finish at once
	`QAP_ASSERT_NXT(a_busy, clk, arst_n, s_tvalid && s_tready && ($signed(s_tdata[127:112]) > 0), !s_tready && !$rose(m_tvalid))

	// a disabled item leaves the block idle
	`QAP_ASSERT_NXT(a_skip, clk, arst_n, s_tvalid && s_tready && ($signed(s_tdata[127:112]) <= 0), s_tready)

endmodule

bind quaternion_attitude_pid qap_checker u_qap_checker (.*);

// ===== tb/quaternion_attitude_pid_test.sv =====
// ----------------------------------------------------------------------------
// quaternion_attitude_pid_test
// self-checking bench for the quaternion attitude pid controller: a queue fed
// driver offers items, a predictor computes the drives per enabled item and a
// monitor compares every result with the oldest prediction
// ----------------------------------------------------------------------------
module quaternion_attitude_pid_test;
	timeunit 1ns;
	timeprecision 1ps;
	import qap_pkg::*;

	localparam int STEPS = 16;
	localparam int SUMW  = 32;
	localparam longint PI20 = 3294199;
	localparam longint HPI20 = 1647099;
	localparam longint ONE28 = longint'(1) << 28;

	logic clk;
	logic arst_n;
	logic s_tvalid, s_tready, m_tvalid, m_tready;
	logic [IN_ITEM_W-1:0] s_tdata;
	logic [OUT_ITEM_W-1:0] m_tdata;
	logic cfg_we;
	logic [CFG_ADDR_W-1:0] cfg_addr;
	logic [GAIN_W-1:0] cfg_wdata;

	quaternion_attitude_pid #(.CORDIC_STEPS(STEPS), .SUM_WIDTH(SUMW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata),
		.cfg_we(cfg_we), .cfg_addr(cfg_addr), .cfg_wdata(cfg_wdata)
	);

	// predictor state
	logic [GAIN_W-1:0] gain_reg [3];
	longint prev_err [3];
	longint err_acc [3];

	logic [IN_ITEM_W-1:0] pending_items [$];
	logic [OUT_ITEM_W-1:0] expected_drives [$];
	int mismatches;
	int src_idle_pct, snk_idle_pct;
	int hold_off;
	bit pause_src;

	initial begin
		clk = 1'b0;
		forever #4 clk = ~clk;
	end

	// generous fixed limit for the roughly 1300 items of the run
	initial begin
		#20ms;
		$display("quaternion_attitude_pid verification failed");
		$finish;
	end

	function automatic longint asr_f(longint v, int s);
		return v >>> s;
	endfunction

	function automatic longint clip(longint v, int w);
		longint hi, lo;
		hi = (longint'(1) << (w - 1)) - 1;
		lo = -hi - 1;
		return v > hi ? hi : (v < lo ? lo : v);
	endfunction

	function automatic longint int_root(longint n);
		longint r, b;
		r = 0;
		b = longint'(1) << 60;
		while (b > n) b = b >> 2;
		while (b != 0) begin
			if (n >= r + b) begin
				n = n - (r + b);
				r = (r >> 1) + b;
			end else begin
				r = r >> 1;
			end
			b = b >> 2;
		end
		return r;
	endfunction

	function automatic longint vector_angle(longint y, longint x);
		longint z, dx, dy;
		int i;
		longint tab [24] = '{823550, 486170, 256879, 130396, 65451, 32757, 16383,
			8192, 4096, 2048, 1024, 512, 256, 128, 64, 32, 16, 8, 4, 2, 1, 0, 0, 0};
		z = 0;
		if (x == 0 && y == 0) return 0;
		if (x < 0) begin
			z = (y >= 0) ? PI20 : -PI20;
			x = -x;
			y = -y;
		end
		for (i = 0; i < STEPS && i < 24; i++) begin
			dx = asr_f(y, i);
			dy = asr_f(x, i);
			if (y > 0) begin
				x += dx; y -= dy; z += tab[i];
			end else begin
				x -= dx; y += dy; z -= tab[i];
			end
		end
		return z;
	endfunction

	function automatic longint to_q12(longint a);
		return asr_f(a + 128, 8);
	endfunction

	// computes the three drives for one item; returns 0 when throttle disables
	function automatic bit predict_drives(input logic [IN_ITEM_W-1:0] d,
			output logic [OUT_ITEM_W-1:0] res);
		longint w, x, y, z, sr, cr, sp, sy, cy, rem;
		longint ang [3];
		longint kp, ki, kd, tgt, sm, e, de, acc, drv;
		int a;
		res = '0;
		w = longint'($signed(d[15:0]));
		x = longint'($signed(d[31:16]));
		y = longint'($signed(d[47:32]));
		z = longint'($signed(d[63:48]));
		if ($signed(d[127:112]) <= 0) return 0;
		sr = 2 * (w * x + y * z);
		cr = ONE28 - 2 * (x * x + y * y);
		ang[0] = to_q12(vector_angle(sr, cr));
		sp = 2 * (w * y - z * x);
		if (sp >= ONE28) ang[1] = to_q12(HPI20);
		else if (sp <= -ONE28) ang[1] = to_q12(-HPI20);
		else begin
			rem = (longint'(1) << 56) - sp * sp;
			ang[1] = to_q12(vector_angle(sp, int_root(rem)));
		end
		sy = 2 * (w * z + x * y);
		cy = ONE28 - 2 * (y * y + z * z);
		ang[2] = to_q12(vector_angle(sy, cy));
		for (a = 0; a < 3; a++) begin
			kp = longint'($signed(gain_reg[a][15:0]));
			ki = longint'($signed(gain_reg[a][31:16]));
			kd = longint'($signed(gain_reg[a][47:32]));
			tgt = longint'($signed(d[64 + 16*a +: 16]));
			sm = clip(err_acc[a] + prev_err[a], SUMW);
			e = clip(tgt - ang[a], 17);
			de = e - prev_err[a];
			acc = kp * e + ki * sm + kd * de;
			drv = clip(asr_f(acc + 128, 8), 24);
			err_acc[a] = sm;
			prev_err[a] = e;
			res[24*a +: 24] = drv[23:0];
		end
		return 1;
	endfunction

	function automatic logic [15:0] rnd_quat();
		case ($urandom_range(0, 5))
			0: return 16'sd16384;
			1: return -16'sd16384;
			2: return 16'h0000;
			default: return 16'($signed($urandom_range(0, 32768)) - 16384);
		endcase
	endfunction

	// unit-ish quaternion from random axis components, normalized in real math
	function automatic logic [IN_ITEM_W-1:0] rnd_item(bit enabled);
		logic [IN_ITEM_W-1:0] d;
		real q [4];
		real n;
		int k;
		for (k = 0; k < 4; k++) q[k] = real'($signed($urandom_range(0, 2000)) - 1000);
		n = $sqrt(q[0]*q[0] + q[1]*q[1] + q[2]*q[2] + q[3]*q[3]);
		if (n == 0.0) n = 1.0;
		for (k = 0; k < 4; k++) begin
			if ($urandom_range(0, 9) == 0) d[16*k +: 16] = rnd_quat();
			else d[16*k +: 16] = 16'($rtoi(q[k] / n * 16384.0 * 0.999));
		end
		for (k = 4; k < 7; k++) begin
			if ($urandom_range(0, 3) == 0) d[16*k +: 16] = 16'($urandom);
			else d[16*k +: 16] = 16'($signed($urandom_range(0, 25736)) - 12868);
		end
		if (enabled) d[127:112] = 16'($urandom_range(1, 32767));
		else d[127:112] = ($urandom_range(0, 1)) ? 16'h0000 : 16'(-$urandom_range(1, 32768));
		return d;
	endfunction

	function automatic logic [IN_ITEM_W-1:0] pack_item(int qw, int qx, int qy, int qz,
			int tr, int tp, int ty, int th);
		return {16'(th), 16'(ty), 16'(tp), 16'(tr), 16'(qz), 16'(qy), 16'(qx), 16'(qw)};
	endfunction

	// driver: new values at the falling edge, item accepted at the rising edge
	always @(negedge clk) begin
		if (!arst_n) begin
			s_tvalid <= 1'b0;
		end else if (s_tvalid && !s_tready) begin
			// hold the offered item
		end else if (pending_items.size() > 0 && !pause_src &&
				$urandom_range(0, 99) >= src_idle_pct) begin
			s_tdata <= pending_items.pop_front();
			s_tvalid <= 1'b1;
		end else begin
			s_tvalid <= 1'b0;
		end
	end

	// prediction taken at acceptance, in item order
	always @(posedge clk) begin
		logic [OUT_ITEM_W-1:0] r;
		if (arst_n && s_tvalid && s_tready) begin
			if (predict_drives(s_tdata, r)) expected_drives.push_back(r);
		end
	end

	// receiver ready, with an optional long hold-off
	always @(negedge clk) begin
		if (hold_off > 0) begin
			hold_off <= hold_off - 1;
			m_tready <= 1'b0;
		end else begin
			m_tready <= ($urandom_range(0, 99) >= snk_idle_pct);
		end
	end

	// monitor
	always @(posedge clk) begin
		logic [OUT_ITEM_W-1:0] exp_r;
		if (arst_n && m_tvalid && m_tready) begin
			if (expected_drives.size() == 0) begin
				mismatches++;
				if (mismatches <= 10) $display("unexpected item %h", m_tdata);
			end else begin
				exp_r = expected_drives.pop_front();
				if (exp_r !== m_tdata) begin
					mismatches++;
					if (mismatches <= 10)
						$display("drive mismatch: roll %h/%h pitch %h/%h yaw %h/%h",
							exp_r[23:0], m_tdata[23:0], exp_r[47:24], m_tdata[47:24],
							exp_r[71:48], m_tdata[71:48]);
				end
			end
		end
	end

	task automatic write_gains(logic [CFG_ADDR_W-1:0] idx, logic [GAIN_W-1:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_addr <= idx;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
		if (idx <= REG_GAINS_YAW) gain_reg[idx] = v;
	endtask

	// waits until the block is idle: queues drained plus a latency margin
	task automatic wait_drained();
		while (pending_items.size() > 0 || s_tvalid || expected_drives.size() > 0)
			@(posedge clk);
		repeat (300) @(posedge clk);
	endtask

	function automatic logic [GAIN_W-1:0] rnd_gains(int mode);
		case (mode)
			0: return {GAIN_W{1'b1}};
			1: return {16'h7fff, 16'h7fff, 16'h7fff};
			2: return {16'h8000, 16'h8000, 16'h8000};
			default: return {16'($urandom_range(0, 1023) - 512),
				16'($urandom_range(0, 255) - 128), 16'($urandom_range(0, 2047) - 1024)};
		endcase
	endfunction

	initial begin
		int ph, k, n;
		arst_n = 1'b0;
		s_tvalid = 1'b0;
		s_tdata = '0;
		m_tready = 1'b0;
		cfg_we = 1'b0;
		cfg_addr = '0;
		cfg_wdata = '0;
		mismatches = 0;
		hold_off = 0;
		pause_src = 1'b0;
		src_idle_pct = 0;
		snk_idle_pct = 0;
		for (k = 0; k < 3; k++) begin
			gain_reg[k] = '0;
			prev_err[k] = 0;
			err_acc[k] = 0;
		end
		repeat (7) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_gains(REG_GAINS_ROLL, {16'h0100, 16'h0010, 16'h0200});
		write_gains(REG_GAINS_PITCH, {16'hff00, 16'h0020, 16'h0180});
		write_gains(REG_GAINS_YAW, {16'h0080, 16'hfff0, 16'hfe00});
		write_gains(2'd3, {GAIN_W{1'b1}}); // index above yaw is ignored

		// directed: identity, extremes, zero vector, pitch near saturation, disabled
		pending_items.push_back(pack_item(16384, 0, 0, 0, 0, 0, 0, 1));
		pending_items.push_back(pack_item(16384, 0, 0, 0, 32767, 32767, 32767, 32767));
		pending_items.push_back(pack_item(16384, 0, 0, 0, -32768, -32768, -32768, 1));
		pending_items.push_back(pack_item(0, 0, 0, 0, 0, 0, 0, 5));
		pending_items.push_back(pack_item(11585, 0, 11585, 0, 100, 200, 300, 9));
		pending_items.push_back(pack_item(11585, 0, -11585, 0, 100, 200, 300, 9));
		pending_items.push_back(pack_item(16384, 16384, 16384, 16384, 0, 0, 0, 9));
		pending_items.push_back(pack_item(-16384, -16384, -16384, -16384, 0, 0, 0, 9));
		pending_items.push_back(pack_item(0, 16384, 0, 0, 0, 0, 0, 9));
		pending_items.push_back(pack_item(0, 0, 0, 16384, 0, 0, 0, 9));
		pending_items.push_back(pack_item(0, 0, 16384, 0, 0, 0, 0, 9));
		pending_items.push_back(pack_item(16384, 0, 0, 0, 0, 0, 0, 0));
		pending_items.push_back(pack_item(16384, 0, 0, 0, 0, 0, 0, -32768));
		pending_items.push_back(pack_item(8192, -8192, 8192, -8192, -5000, 5000, -9, 3));
		pending_items.push_back(pack_item(-1, -1, -1, -1, -1, -1, -1, 32767));
		src_idle_pct = 20;
		snk_idle_pct = 75;
		wait_drained();

		// random phases through several gain settings, extremes included
		for (ph = 0; ph < 6; ph++) begin
			write_gains(REG_GAINS_ROLL, rnd_gains(ph));
			write_gains(REG_GAINS_PITCH, rnd_gains(ph == 0 ? 2 : ph));
			write_gains(REG_GAINS_YAW, rnd_gains(ph == 0 ? 1 : ph));
			if (ph < 2) begin
				src_idle_pct = 20; snk_idle_pct = 75;
			end else if (ph < 4) begin
				src_idle_pct = 75; snk_idle_pct = 20;
			end else begin
				src_idle_pct = 0; snk_idle_pct = 0;
			end
			n = 205;
			for (k = 0; k < n; k++) pending_items.push_back(rnd_item($urandom_range(0, 9) != 0));
			if (ph == 1) begin
				// long receiver stall while the sender keeps offering
				@(negedge clk);
				hold_off = 2000;
			end
			if (ph == 3) begin
				// sender pause until every result has arrived
				while (pending_items.size() > n / 2) @(posedge clk);
				pause_src = 1'b1;
				while (s_tvalid || expected_drives.size() > 0) @(posedge clk);
				pause_src = 1'b0;
			end
			wait_drained();
		end

		if (mismatches == 0 && expected_drives.size() == 0) begin
			$display("quaternion_attitude_pid verification clean");
		end else begin
			$display("quaternion_attitude_pid verification failed");
		end
		$finish;
	end
endmodule
